### rtl/core/cce_pkg.sv
// shared types and constants of the consensus clustering entry
package cce_pkg;

    // input item
    typedef struct packed {
        logic       op;
        logic [9:0] cell_a;
        logic [9:0] cell_b;
        logic [5:0] solution;
        logic [7:0] label;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [21:0] consensus;
        logic [6:0]  shared_count;
        logic        bad_label;
        logic        was_query;
    } t_out_item;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register indexes, decoded from paddr[2]
    localparam logic REG_SOL_COUNT = 1'b0;
    localparam logic REG_CLU_COUNT = 1'b1;

    // field widths
    localparam int CELL_IN_W  = 10;
    localparam int SOL_IN_W   = 6;
    localparam int LABEL_IN_W = 8;

    // count, pair count and quotient widths
    localparam int N_W    = 7;
    localparam int P_W    = 13;
    localparam int FRAC_W = 16;
    localparam int Q_W    = P_W - N_W + FRAC_W;

endpackage

### rtl/core/clustering_consensus_entry.sv
// consensus clustering entry: label store, pair walk and q16 consensus
// sequence: a load passes the index wrap, stores its label and is answered;
//   a query passes the wrap, walks n solutions (n = effective solution count),
//   one label pair a cycle from the two read ports of the label
//   memory, then runs the divider (one quotient bit a cycle, 22 bits)
// throughput: one item at a time, the next item is taken as soon as the
//   result moves to the output register
// reset: synchronous, active low; clears control state and sets both counts
//   to 1; the label memory is not cleared and must be loaded before a query
module clustering_consensus_entry #(
    parameter int MAX_CELLS     = 1024,
    parameter int MAX_SOLUTIONS = 64,
    parameter int LABEL_BITS    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cce_pkg::t_in_item  i_in_item,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cce_pkg::t_out_item o_out_item,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import cce_pkg::*;

    // memory geometry: row per cell, column per solution
    localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int SOL_W  = (MAX_SOLUTIONS > 1) ? $clog2(MAX_SOLUTIONS) : 1;
    localparam int ADDR_W = CELL_W + SOL_W;
    localparam int DEPTH  = 1 << ADDR_W;

    // largest walk length: the solution limit, capped at the 127 that the 7-bit count register can ask for
    localparam int NMAX = (MAX_SOLUTIONS < 127) ? MAX_SOLUTIONS : 127;
    localparam logic [N_W-1:0] NMAX_V = N_W'(NMAX);
    localparam logic [16:0] LAB_MAX_V = 17'((1 << LABEL_BITS) - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WRAP = 3'd1;
    localparam logic [2:0] ST_WALK = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // configuration registers
    logic [N_W-1:0]        r_sol;
    logic [LABEL_IN_W-1:0] r_clu;

    // sequencer registers and their next values
    logic [2:0]            r_state, n_state;
    logic                  r_op, n_op;
    logic [LABEL_IN_W-1:0] r_label, n_label;
    logic [N_W-1:0]        r_n, n_n;
    logic [SOL_W-1:0]      r_s, n_s;
    logic [N_W-1:0]        r_iss, n_iss;
    logic                  r_cmp_v, n_cmp_v;
    logic [N_W-1:0]        r_count, n_count;
    logic                  r_same, n_same;
    logic [P_W-1:0]        r_p, n_p;
    logic                  r_div_start, n_div_start;
    t_out_item             r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out_item, n_out_item;

    logic                  w_in_acc;
    logic                  w_va, w_vb, w_vs, w_wrap_val;
    logic [CELL_W-1:0]     w_ca, w_cb;
    logic [SOL_W-1:0]      w_sol;
    logic                  w_bad;
    logic                  w_we;
    logic [N_W-1:0]        w_n_eff;
    logic [N_W-1:0]        w_cm1;
    logic [2*N_W-1:0]      w_prod;
    logic [LABEL_BITS-1:0] w_rd_a, w_rd_b;
    logic                  w_div_done;
    logic [Q_W-1:0]        w_quot;

    // register port: always ready, writes on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLU_COUNT) ? {24'd0, r_clu} : {25'd0, r_sol};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sol <= N_W'(1);
            r_clu <= LABEL_IN_W'(1);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_SOL_COUNT) begin
                r_sol <= pwdata[N_W-1:0];
            end else begin
                r_clu <= pwdata[LABEL_IN_W-1:0];
            end
        end
    end

    // one item in flight; results wait in the output register
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // wrap the item indexes into the configured geometry
    cce_wrap #(.IN_W(CELL_IN_W), .MOD(MAX_CELLS), .OUT_W(CELL_W)) u_wrap_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_val   (w_in_acc),
        .i_value (i_in_item.cell_a),
        .o_val   (w_va),
        .o_rem   (w_ca)
    );

    cce_wrap #(.IN_W(CELL_IN_W), .MOD(MAX_CELLS), .OUT_W(CELL_W)) u_wrap_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_val   (w_in_acc),
        .i_value (i_in_item.cell_b),
        .o_val   (w_vb),
        .o_rem   (w_cb)
    );

    cce_wrap #(.IN_W(SOL_IN_W), .MOD(MAX_SOLUTIONS), .OUT_W(SOL_W)) u_wrap_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_val   (w_in_acc),
        .i_value (i_in_item.solution),
        .o_val   (w_vs),
        .o_rem   (w_sol)
    );

    assign w_wrap_val = w_va && w_vb && w_vs;

    // label range check: zero, above cluster count, or too wide to store
    assign w_bad = (r_label == '0) || (r_label > r_clu)
                || (17'(r_label) > LAB_MAX_V);

    // walk length, count zero acts as one, counts above NMAX clamp to NMAX
    assign w_n_eff = (r_sol == '0) ? N_W'(1) : ((r_sol > NMAX_V) ? NMAX_V : r_sol);

    // c * (c - 1), halved on the way into r_p
    assign w_cm1  = (r_count == '0) ? '0 : (r_count - 1'b1);
    assign w_prod = {{N_W{1'b0}}, r_count} * {{N_W{1'b0}}, w_cm1};

    // label memory: port a follows cell_a, port b follows cell_b during the walk
    cce_ram #(.WIDTH(LABEL_BITS), .DEPTH(DEPTH)) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   ({w_ca, w_sol}),
        .i_wdata   (LABEL_BITS'(r_label)),
        .i_raddr_a ({w_ca, r_s}),
        .i_raddr_b ({w_cb, r_s}),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    cce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_p),
        .i_divisor  (r_n),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_label     = r_label;
        n_n         = r_n;
        n_s         = r_s;
        n_iss       = r_iss;
        n_cmp_v     = r_cmp_v;
        n_count     = r_count;
        n_same      = r_same;
        n_p         = r_p;
        n_div_start = 1'b0;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        w_we        = 1'b0;

        // consumer took the waiting result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_op    = i_in_item.op;
                    n_label = i_in_item.label;
                    n_state = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (w_wrap_val) begin
                    if (r_op == OP_LOAD) begin
                        // store the label unless rejected, then acknowledge
                        w_we                = !w_bad;
                        n_res.consensus     = '0;
                        n_res.shared_count  = '0;
                        n_res.bad_label     = w_bad;
                        n_res.was_query     = 1'b0;
                        n_state             = ST_DONE;
                    end else begin
                        n_n     = w_n_eff;
                        n_s     = '0;
                        n_iss   = '0;
                        n_cmp_v = 1'b0;
                        n_count = '0;
                        n_same  = (w_ca == w_cb);
                        n_state = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // issue one solution per cycle, compare it in the next cycle
                n_cmp_v = 1'b0;
                if (r_iss != r_n) begin
                    n_s     = r_s + 1'b1;
                    n_iss   = r_iss + 1'b1;
                    n_cmp_v = 1'b1;
                end
                if (r_cmp_v && (w_rd_a == w_rd_b)) begin
                    n_count = r_count + 1'b1;
                end
                if ((r_iss == r_n) && !r_cmp_v) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // a cell against itself gives one over n
                n_p         = r_same ? P_W'(1) : w_prod[P_W:1];
                n_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_res.consensus    = w_quot;
                    n_res.shared_count = r_count;
                    n_res.bad_label    = 1'b0;
                    n_res.was_query    = 1'b1;
                    n_state            = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_item  = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_v     <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_v     <= n_cmp_v;
            r_div_start <= n_div_start;
            r_out_valid <= n_out_valid;
        end
        r_op       <= n_op;
        r_label    <= n_label;
        r_n        <= n_n;
        r_s        <= n_s;
        r_iss      <= n_iss;
        r_count    <= n_count;
        r_same     <= n_same;
        r_p        <= n_p;
        r_res      <= n_res;
        r_out_item <= n_out_item;
    end

    // a load acknowledge carries no consensus and no count
    a_load_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.was_query) |->
            (o_out_item.consensus == '0) && (o_out_item.shared_count == '0))
        else $error("load acknowledge with nonzero query fields");

    // the shared count never exceeds the walked solutions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_count <= r_n))
        else $error("shared count above walk length");

    // an accepted item blocks the input until its result is produced
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input not stalled after accept");

    // the label memory is written only by a load
    a_write_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_op == OP_LOAD) && (r_state == ST_WRAP)))
        else $error("label memory written outside a load");

endmodule

### rtl/core/cce_ram.sv
// generic single write, dual read memory with registered read data
module cce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

### rtl/core/cce_wrap.sv
// two stage index reduction modulo a constant by reciprocal multiply
module cce_wrap #(
    parameter int IN_W  = 10,
    parameter int MOD   = 1024,
    parameter int OUT_W = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_val,
    input  logic [IN_W-1:0]  i_value,
    output logic             o_val,
    output logic [OUT_W-1:0] o_rem
);

    localparam int RECIP = (1 << IN_W) / MOD;
    localparam int R_W   = IN_W + 1;
    localparam int M_W   = $clog2(MOD + 1);
    localparam int D_W   = IN_W + 1 + M_W;
    localparam logic [R_W-1:0] RC   = R_W'(RECIP);
    localparam logic [D_W-1:0] MODV = D_W'(MOD);

    logic [IN_W+R_W-1:0] w_prod;
    logic [R_W-1:0]      r_q;
    logic [IN_W-1:0]     r_v;
    logic                r_v1;
    logic [D_W-1:0]      w_qm;
    logic [D_W-1:0]      w_diff;
    logic [D_W-1:0]      w_fix;

    // quotient estimate, low by at most one
    assign w_prod = {{R_W{1'b0}}, i_value} * {{IN_W{1'b0}}, RC};
    assign w_qm   = D_W'(r_q) * MODV;
    assign w_diff = D_W'(r_v) - w_qm;
    assign w_fix  = (w_diff >= MODV) ? (w_diff - MODV) : w_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            o_val <= 1'b0;
        end else begin
            r_v1  <= i_val;
            o_val <= r_v1;
        end
        if (i_val) begin
            r_q <= w_prod[IN_W+R_W-1:IN_W];
            r_v <= i_value;
        end
        if (r_v1) begin
            o_rem <= w_fix[OUT_W-1:0];
        end
    end

endmodule

### rtl/core/cce_div.sv
// restoring divider, one quotient bit per cycle, pair count in q16 over n
module cce_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [cce_pkg::P_W-1:0]  i_dividend,
    input  logic [cce_pkg::N_W-1:0]  i_divisor,
    output logic                     o_done,
    output logic [cce_pkg::Q_W-1:0]  o_quot
);

    import cce_pkg::*;

    localparam int CNT_W = $clog2(Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(Q_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_div;
    logic [Q_W-1:0]   r_sh;
    logic [N_W:0]     w_trial;
    logic             w_ge;
    logic [N_W:0]     w_sub;

    assign w_trial = {r_rem, r_sh[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_sub   = w_trial - {1'b0, r_div};
    assign o_quot  = r_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            // top bits of the dividend are already below the divisor
            r_rem <= i_dividend[P_W-1:P_W-N_W];
            r_sh  <= {i_dividend[P_W-N_W-1:0], {FRAC_W{1'b0}}};
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[N_W-1:0] : w_trial[N_W-1:0];
            r_sh  <= {r_sh[Q_W-2:0], w_ge};
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without work");

endmodule

### sim/tb_top.sv
// testbench for the consensus clustering entry: label loads, pair queries and register settings
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    clustering_consensus_entry dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow of the block: register values and the label memory
    logic [6:0] sol_count_q = 7'd1;
    logic [7:0] clu_count_q = 8'd1;
    logic [7:0] label_mem     [1024][64];
    bit         label_written [1024][64];

    // answers still owed by the block, oldest first
    t_out_item  pending_answers[$];
    int         mismatches = 0;
    int         items_sent = 0;

    // sender burst shaping and receiver stall pattern knobs
    int         gap_pct    = 0;
    int         burst_left = 0;
    int         stall_pct  = 0;
    int         hold_req   = 0;
    int         hold_seen  = 0;
    int         hold_left  = 0;
    int         stall_run  = 0;

    // two cells loaded across all 64 solutions, reused by later tests
    logic [9:0] walk_a;
    logic [9:0] walk_b;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // generous limit, far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    // solution count as the walk sees it: zero acts as one, clamp at 64
    function automatic int walk_length();
        if (sol_count_q == 7'd0)
            return 1;
        if (sol_count_q > 7'd64)
            return 64;
        return int'(sol_count_q);
    endfunction

    // expected answer of one accepted item; loads update the shadow memory
    function automatic t_out_item predict_answer(input t_in_item it);
        t_out_item       r;
        int              n;
        int              c;
        int              s;
        logic            bad;
        longint unsigned pairs;
        longint unsigned cons;
        r = '0;
        if (it.op == OP_LOAD) begin
            // label zero and labels above the cluster count are rejected
            bad = (it.label == 8'd0) || (it.label > clu_count_q);
            if (!bad) begin
                label_mem[it.cell_a][it.solution]     = it.label;
                label_written[it.cell_a][it.solution] = 1'b1;
            end
            r.bad_label = bad;
        end else begin
            n = walk_length();
            c = 0;
            for (s = 0; s < n; s++) begin
                if (label_mem[it.cell_a][s] == label_mem[it.cell_b][s])
                    c++;
            end
            if (it.cell_a == it.cell_b) begin
                // a cell with itself answers one over the solution count
                cons = 64'd65536 / n;
            end else begin
                pairs = (c > 0) ? (longint'(c) * (c - 1)) / 2 : 0;
                cons  = (pairs << 16) / n;
            end
            if (cons > 64'h3F_FFFF)
                cons = 64'h3F_FFFF;
            if (c > 127)
                c = 127;
            r.consensus    = cons[21:0];
            r.shared_count = c[6:0];
            r.was_query    = 1'b1;
        end
        return r;
    endfunction

    // every solution the walk will read has been written for this cell
    function automatic bit cell_ready(input logic [9:0] cell_idx);
        int s;
        for (s = 0; s < walk_length(); s++) begin
            if (!label_written[cell_idx][s])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] valid_label();
        // lean on low labels so that pairs share labels often
        if ($urandom_range(1, 0) == 1)
            return 8'($urandom_range(clu_count_q < 8'd3 ? clu_count_q : 8'd3, 1));
        return 8'($urandom_range(clu_count_q, 1));
    endfunction

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_out_item expd;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                flag_mismatch($sformatf("result %h with no answer pending", o_out_item));
            end else begin
                expd = pending_answers.pop_front();
                if (o_out_item.consensus !== expd.consensus)
                    flag_mismatch($sformatf("consensus expected %0d got %0d",
                                            expd.consensus, o_out_item.consensus));
                if (o_out_item.shared_count !== expd.shared_count)
                    flag_mismatch($sformatf("shared_count expected %0d got %0d",
                                            expd.shared_count, o_out_item.shared_count));
                if (o_out_item.bad_label !== expd.bad_label)
                    flag_mismatch($sformatf("bad_label expected %0b got %0b",
                                            expd.bad_label, o_out_item.bad_label));
                if (o_out_item.was_query !== expd.was_query)
                    flag_mismatch($sformatf("was_query expected %0b got %0b",
                                            expd.was_query, o_out_item.was_query));
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: random stall runs, plus a long hold on request
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99, 0) < stall_pct) begin
            stall_run = $urandom_range(5, 0);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one item and wait until the block takes it
    task automatic send_item(input t_in_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            if ($urandom_range(99, 0) < gap_pct) begin
                repeat ($urandom_range(6, 1)) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_answers.insert(pending_answers.size(), predict_answer(it));
        items_sent++;
    endtask

    // fields a load ignores are random so that every bit moves
    task automatic load_label(input logic [9:0] cell_idx, input logic [5:0] sol,
                              input logic [7:0] lbl);
        t_in_item it;
        it.op       = OP_LOAD;
        it.cell_a   = cell_idx;
        it.cell_b   = 10'($urandom);
        it.solution = sol;
        it.label    = lbl;
        send_item(it);
    endtask

    task automatic query_pair(input logic [9:0] cell_x, input logic [9:0] cell_y);
        t_in_item it;
        it.op       = OP_QUERY;
        it.cell_a   = cell_x;
        it.cell_b   = cell_y;
        it.solution = 6'($urandom);
        it.label    = 8'($urandom);
        send_item(it);
    endtask

    // fill in any solution the walk would read but that was never written
    task automatic fill_cell(input logic [9:0] cell_idx);
        int s;
        for (s = 0; s < walk_length(); s++) begin
            if (!label_written[cell_idx][s])
                load_label(cell_idx, 6'(s), valid_label());
        end
    endtask

    // drop valid and let every owed answer drain out
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // register write, setup then access, only with the block idle
    task automatic write_reg(input logic idx, input logic [31:0] value);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SOL_COUNT)
            sol_count_q = value[6:0];
        else
            clu_count_q = value[7:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // field extremes, both operations and the named corner cases
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(REG_SOL_COUNT, 32'd1);
        write_reg(REG_CLU_COUNT, 32'd255);
        load_label(10'd0, 6'd0, 8'd255);
        load_label(10'd1023, 6'd63, 8'd255);
        load_label(10'd1023, 6'd0, 8'd1);
        load_label(10'h155, 6'd0, 8'd0);        // label zero is rejected
        load_label(10'h2AA, 6'h2A, 8'd170);
        query_pair(10'd0, 10'd1023);            // labels differ, nothing shared
        query_pair(10'd1023, 10'd0);
        query_pair(10'd0, 10'd0);               // cell with itself
        load_label(10'd1023, 6'd0, 8'd255);
        query_pair(10'd0, 10'd1023);            // one shared solution, no pair
        load_label(10'd0, 6'd1, 8'd255);
        load_label(10'd1023, 6'd1, 8'd255);
        write_reg(REG_SOL_COUNT, 32'd2);
        query_pair(10'd0, 10'd1023);            // one pair over two solutions
        query_pair(10'd1023, 10'd1023);
        write_reg(REG_CLU_COUNT, 32'd2);
        load_label(10'd5, 6'd0, 8'd3);          // above the cluster count
        load_label(10'd5, 6'd0, 8'd2);
        load_label(10'd5, 6'd1, 8'd1);
        write_reg(REG_CLU_COUNT, 32'd0);
        load_label(10'd5, 6'd1, 8'd1);          // cluster count zero rejects all
        write_reg(REG_SOL_COUNT, 32'd0);        // zero walks one solution
        query_pair(10'd0, 10'd5);
        query_pair(10'd5, 10'd5);
    endtask

    // two cells over every solution: full walk, clamped count, relabeling
    task automatic test_full_walk();
        int s;
        gap_pct   = 30;
        stall_pct = 20;
        walk_a = 10'($urandom);
        walk_b = walk_a ^ 10'($urandom_range(1023, 1));
        write_reg(REG_CLU_COUNT, 32'd1);
        write_reg(REG_SOL_COUNT, 32'd64);
        for (s = 0; s < 64; s++) begin
            load_label(walk_a, 6'(s), 8'd1);
            load_label(walk_b, 6'(s), 8'd1);
        end
        // every solution shared: the largest consensus
        query_pair(walk_a, walk_b);
        query_pair(walk_b, walk_b);
        write_reg(REG_SOL_COUNT, 32'd127);
        query_pair(walk_b, walk_a);
        write_reg(REG_CLU_COUNT, 32'd2);
        repeat (20) begin
            load_label(($urandom_range(1, 0) == 1) ? walk_a : walk_b,
                       6'($urandom), valid_label());
        end
        query_pair(walk_a, walk_b);
        write_reg(REG_SOL_COUNT, 32'd33);
        query_pair(walk_a, walk_b);
        query_pair(walk_a, walk_a);
        write_reg(REG_SOL_COUNT, 32'd64);
        query_pair(walk_b, walk_a);
    endtask

    // phases of random traffic, each under its own register setting
    task automatic test_random();
        int         sol_set[6] = '{1, 4, 12, 2, 7, 5};
        int         clu_set[6] = '{255, 2, 3, 1, 255, 4};
        int         ph;
        int         start;
        int         pick;
        logic [9:0] pool[3];
        logic [9:0] cell_x;
        logic [9:0] cell_y;
        for (ph = 0; ph < 6; ph++) begin
            write_reg(REG_SOL_COUNT, 32'(sol_set[ph]));
            write_reg(REG_CLU_COUNT, 32'(clu_set[ph]));
            gap_pct   = (ph % 3 == 0) ? 0 : 40;
            stall_pct = (ph % 2 == 0) ? 0 : 35;
            pool[0] = ($urandom_range(1, 0) == 1) ? walk_a : walk_b;
            pool[1] = 10'($urandom);
            pool[2] = 10'($urandom);
            start = items_sent;
            while (items_sent - start < 45) begin
                pick = $urandom_range(99, 0);
                if (pick < 55) begin
                    // query two pool cells, now and then a cell with itself
                    cell_x = pool[$urandom_range(2, 0)];
                    cell_y = ($urandom_range(4, 0) == 0) ? cell_x : pool[$urandom_range(2, 0)];
                    fill_cell(cell_x);
                    fill_cell(cell_y);
                    query_pair(cell_x, cell_y);
                end else if (pick < 75) begin
                    load_label(pool[$urandom_range(2, 0)],
                               6'($urandom_range(walk_length() - 1, 0)), valid_label());
                end else if (pick < 85) begin
                    // rejected label: zero or above the cluster count
                    if (clu_count_q == 8'd255 || $urandom_range(1, 0) == 1)
                        load_label(10'($urandom), 6'($urandom), 8'd0);
                    else
                        load_label(10'($urandom), 6'($urandom),
                                   8'($urandom_range(255, clu_count_q + 1)));
                end else begin
                    load_label(10'($urandom), 6'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_backpressure();
        wait_idle();
        gap_pct   = 0;
        stall_pct = 0;
        hold_req++;
        repeat (12) begin
            if ($urandom_range(1, 0) == 1)
                query_pair(walk_a, walk_b);
            else
                load_label(walk_b, 6'($urandom_range(walk_length() - 1, 0)), valid_label());
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_walk();
        test_random();
        test_backpressure();

        wait_idle();
        stall_pct = 0;
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/cce_pkg.sv
rtl/core/cce_ram.sv
rtl/core/cce_wrap.sv
rtl/core/cce_div.sv
rtl/core/clustering_consensus_entry.sv
sim/tb_top.sv
